// ===== hdl/plr_pkg.sv =====
// shared types and constants of the patterned line rasterizer
package plr_pkg;

    localparam int COORD_W  = 12;
    localparam int ERROR_W  = 14;
    localparam int OFFSET_W = 14;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_DASH_PATTERN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_COLOR   = 2'd1;

    localparam logic [15:0] DASH_PATTERN_RESET = 16'hFFFF;
    localparam logic [3:0]  DRAW_COLOR_RESET   = 4'd15;

    typedef struct packed {
        logic                      op;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } t_in_item;

    typedef struct packed {
        logic                write_enable;
        logic [OFFSET_W-1:0] byte_offset;
        logic [1:0]          pixel_slot;
        logic [1:0]          pixel_value;
        logic                last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] dash_pattern;
        logic [3:0]  draw_color;
    } t_cfg;

    typedef struct packed {
        logic                      is_step;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic [COORD_W-1:0]        dx;
        logic [COORD_W-1:0]        dy;
        logic                      x_neg;
        logic                      y_neg;
        logic signed [ERROR_W-1:0] err;
    } t_cmd;

endpackage

// ===== hdl/patterned_line_rasterizer_top.sv =====
// top level of the patterned line rasterizer: config registers and engine wiring
// Takes one item per clock while not stalled and gives one result per item. A start
// item loads the endpoints and yields an all-zero result; each step item on an active
// line runs one Bresenham iteration and yields the pixel's byte offset, slot within
// the byte, colour bits and an end-point flag. The drawing engine performs one
// iteration per clock unless the output stalls, so sustained throughput is one item
// per cycle. A queue of QUEUE_DEPTH commands sits between the input and the engine;
// accepted items are written into it, then popped; results sit in an output register.
// Configuration writes are always ready and must be done while the block is idle.
module patterned_line_rasterizer_top #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200,
    parameter int ROW_BYTES     = 80,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  plr_pkg::t_in_item                   i_in_item,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output plr_pkg::t_out_item                  o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [plr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [plr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import plr_pkg::*;

    t_cfg r_cfg, n_cfg;
    t_cmd w_push_data;
    t_cmd w_pop_data;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DASH_PATTERN: n_cfg.dash_pattern = i_cfg_data[15:0];
                CFG_DRAW_COLOR:   n_cfg.draw_color   = i_cfg_data[3:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dash_pattern <= DASH_PATTERN_RESET;
            r_cfg.draw_color   <= DRAW_COLOR_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    plr_front u_front (
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    plr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_empty     (w_empty)
    );

    plr_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .ROW_BYTES     (ROW_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_pop_data),
        .i_cmd_empty (w_empty),
        .o_cmd_pop   (w_pop),
        .i_cfg       (r_cfg),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("command popped from empty queue");

    a_engine_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_empty && !o_out_valid) |=> o_out_valid)
        else $error("engine idle with a queued command");

    a_unwritten_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.write_enable) |->
        (o_out_item.byte_offset == '0 && o_out_item.pixel_slot == '0
         && o_out_item.pixel_value == '0))
        else $error("unwritten pixel carries address or colour");

    a_color_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.write_enable) |->
        (o_out_item.pixel_value == r_cfg.draw_color[1:0]))
        else $error("pixel colour differs from draw colour");

endmodule

// ===== hdl/plr_front.sv =====
// front end: accepts items and works out line setup for start commands
module plr_front (
    input  logic            i_in_valid,
    input  plr_pkg::t_in_item i_in_item,
    output logic            o_in_stall,
    input  logic            i_full,
    output logic            o_push,
    output plr_pkg::t_cmd   o_push_data
);
    import plr_pkg::*;

    logic signed [COORD_W:0] w_diff_x;
    logic signed [COORD_W:0] w_diff_y;
    logic [COORD_W-1:0]      w_dx;
    logic [COORD_W-1:0]      w_dy;

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        w_diff_x = {i_in_item.end_x[COORD_W-1], i_in_item.end_x}
                 - {i_in_item.start_x[COORD_W-1], i_in_item.start_x};
        w_diff_y = {i_in_item.end_y[COORD_W-1], i_in_item.end_y}
                 - {i_in_item.start_y[COORD_W-1], i_in_item.start_y};
        w_dx = w_diff_x[COORD_W] ? COORD_W'(-w_diff_x) : w_diff_x[COORD_W-1:0];
        w_dy = w_diff_y[COORD_W] ? COORD_W'(-w_diff_y) : w_diff_y[COORD_W-1:0];

        o_push_data.is_step = (i_in_item.op == OP_STEP);
        o_push_data.x1      = i_in_item.start_x;
        o_push_data.y1      = i_in_item.start_y;
        o_push_data.x2      = i_in_item.end_x;
        o_push_data.y2      = i_in_item.end_y;
        o_push_data.dx      = w_dx;
        o_push_data.dy      = w_dy;
        o_push_data.x_neg   = !(i_in_item.start_x < i_in_item.end_x);
        o_push_data.y_neg   = !(i_in_item.start_y < i_in_item.end_y);
        o_push_data.err     = $signed({2'b00, w_dx}) - $signed({2'b00, w_dy});
    end

endmodule

// ===== hdl/plr_queue.sv =====
// small command queue between front end and drawing engine
module plr_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  plr_pkg::t_cmd i_push_data,
    output logic          o_full,
    input  logic          i_pop,
    output plr_pkg::t_cmd o_pop_data,
    output logic          o_empty
);
    import plr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full     = (r_count == FULL_CNT);
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== hdl/plr_back.sv =====
// drawing engine: bresenham iteration, pixel address and output register
module plr_back #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200,
    parameter int ROW_BYTES     = 80
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  plr_pkg::t_cmd      i_cmd,
    input  logic               i_cmd_empty,
    output logic               o_cmd_pop,
    input  plr_pkg::t_cfg      i_cfg,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output plr_pkg::t_out_item o_out_item
);
    import plr_pkg::*;

    localparam logic [COORD_W-1:0] WIDTH_LIM  = COORD_W'(SCREEN_WIDTH);
    localparam logic [COORD_W-1:0] HEIGHT_LIM = COORD_W'(SCREEN_HEIGHT);
    localparam int ROWB_W = $clog2(ROW_BYTES + 1);
    localparam int PROD_W = COORD_W + ROWB_W + 1;
    localparam logic [ROWB_W-1:0] ROW_B = ROWB_W'(ROW_BYTES);

    logic signed [COORD_W-1:0] r_pos_x, n_pos_x;
    logic signed [COORD_W-1:0] r_pos_y, n_pos_y;
    logic signed [COORD_W-1:0] r_goal_x, n_goal_x;
    logic signed [COORD_W-1:0] r_goal_y, n_goal_y;
    logic [COORD_W-1:0]        r_dx, n_dx;
    logic [COORD_W-1:0]        r_dy, n_dy;
    logic                      r_x_neg, n_x_neg;
    logic                      r_y_neg, n_y_neg;
    logic signed [ERROR_W-1:0] r_err, n_err;
    logic [3:0]                r_pat, n_pat;
    logic                      r_active, n_active;
    logic                      r_out_valid, n_out_valid;
    t_out_item                 r_out_item, n_out_item;

    logic                      w_enabled;
    logic                      w_on_screen;
    logic                      w_is_last;
    logic signed [ERROR_W:0]   w_e2;
    logic                      w_move_x;
    logic                      w_move_y;
    logic signed [ERROR_W:0]   w_err_sum;
    logic [PROD_W-1:0]         w_offset;

    assign o_cmd_pop   = !i_cmd_empty && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        w_enabled   = i_cfg.dash_pattern[r_pat];
        w_on_screen = !r_pos_x[COORD_W-1] && (r_pos_x < WIDTH_LIM)
                   && !r_pos_y[COORD_W-1] && (r_pos_y < HEIGHT_LIM);
        w_is_last   = (r_pos_x == r_goal_x) && (r_pos_y == r_goal_y);
        w_offset    = PROD_W'(r_pos_y) * PROD_W'(ROW_B) + PROD_W'(r_pos_x[COORD_W-1:2]);
        w_e2        = {r_err, 1'b0};
        w_move_x    = w_e2 > -$signed({3'b000, r_dy});
        w_move_y    = w_e2 < $signed({3'b000, r_dx});
        w_err_sum   = {r_err[ERROR_W-1], r_err}
                    - (w_move_x ? $signed({3'b000, r_dy}) : '0)
                    + (w_move_y ? $signed({3'b000, r_dx}) : '0);

        n_pos_x  = r_pos_x;
        n_pos_y  = r_pos_y;
        n_goal_x = r_goal_x;
        n_goal_y = r_goal_y;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_x_neg  = r_x_neg;
        n_y_neg  = r_y_neg;
        n_err    = r_err;
        n_pat    = r_pat;
        n_active = r_active;
        n_out_item  = r_out_item;
        n_out_valid = r_out_valid;

        if (o_cmd_pop) begin
            n_out_valid = 1'b1;
            n_out_item  = '0;
            if (!i_cmd.is_step) begin
                n_pos_x  = i_cmd.x1;
                n_pos_y  = i_cmd.y1;
                n_goal_x = i_cmd.x2;
                n_goal_y = i_cmd.y2;
                n_dx     = i_cmd.dx;
                n_dy     = i_cmd.dy;
                n_x_neg  = i_cmd.x_neg;
                n_y_neg  = i_cmd.y_neg;
                n_err    = i_cmd.err;
                n_pat    = '0;
                n_active = 1'b1;
            end else if (r_active) begin
                if (w_enabled && w_on_screen) begin
                    n_out_item.write_enable = 1'b1;
                    n_out_item.byte_offset  = w_offset[OFFSET_W-1:0];
                    n_out_item.pixel_slot   = r_pos_x[1:0];
                    n_out_item.pixel_value  = i_cfg.draw_color[1:0];
                end
                if (w_is_last) begin
                    n_out_item.last = 1'b1;
                    n_active        = 1'b0;
                end else begin
                    n_err = w_err_sum[ERROR_W-1:0];
                    if (w_move_x) begin
                        n_pos_x = r_x_neg ? r_pos_x - 1'b1 : r_pos_x + 1'b1;
                    end
                    if (w_move_y) begin
                        n_pos_y = r_y_neg ? r_pos_y - 1'b1 : r_pos_y + 1'b1;
                    end
                    n_pat = r_pat + 1'b1;
                end
            end
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos_x    <= n_pos_x;
        r_pos_y    <= n_pos_y;
        r_goal_x   <= n_goal_x;
        r_goal_y   <= n_goal_y;
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_x_neg    <= n_x_neg;
        r_y_neg    <= n_y_neg;
        r_err      <= n_err;
        r_pat      <= n_pat;
        r_out_item <= n_out_item;
    end

endmodule

// ===== bench/tb_patterned_line_rasterizer_top.sv =====
// testbench for the patterned line rasterizer: queued line commands, predicted pixels, beat checks
module tb_patterned_line_rasterizer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import plr_pkg::*;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 200;
    localparam int ROW_BYTES     = 80;
    localparam int SETTLE_CYCLES = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    t_in_item              i_in_item = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_in_item  draw_cmds[$];
    t_out_item expected_pixels[$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        mismatches = 0;

    // predicted engine state and registers
    logic [15:0]               dash_mask = DASH_PATTERN_RESET;
    logic [3:0]                pen_color = DRAW_COLOR_RESET;
    logic signed [COORD_W-1:0] pen_x = '0;
    logic signed [COORD_W-1:0] pen_y = '0;
    logic signed [COORD_W-1:0] goal_x = '0;
    logic signed [COORD_W-1:0] goal_y = '0;
    logic [COORD_W-1:0]        run_x = '0;
    logic [COORD_W-1:0]        run_y = '0;
    logic                      x_back = 1'b0;
    logic                      y_back = 1'b0;
    logic signed [ERROR_W-1:0] bres_err = '0;
    logic [3:0]                dash_pos = '0;
    logic                      drawing = 1'b0;

    logic [15:0]          dash_sets [6] = '{16'hFFFF, 16'h0000, 16'hA5C3, 16'hFFFF, 16'h0, 16'h8001};
    logic [CFG_DATA_W-1:0] color_sets [6] = '{16'h000F, 16'h0000, 16'h0002, 16'h000F, 16'h0,
                                             16'hFFF1};

    patterned_line_rasterizer_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_out_item rasterize_beat(input t_in_item cmd);
        t_out_item pix;
        int        ax, ay, bx, by, e2;
        logic      pix_on, pix_fits;
        pix = '0;
        if (cmd.op == OP_START) begin
            ax = int'(cmd.start_x);
            ay = int'(cmd.start_y);
            bx = int'(cmd.end_x);
            by = int'(cmd.end_y);
            run_x = COORD_W'((bx >= ax) ? bx - ax : ax - bx);
            run_y = COORD_W'((by >= ay) ? by - ay : ay - by);
            x_back = !(ax < bx);
            y_back = !(ay < by);
            bres_err = ERROR_W'(int'(run_x) - int'(run_y));
            pen_x = cmd.start_x;
            pen_y = cmd.start_y;
            goal_x = cmd.end_x;
            goal_y = cmd.end_y;
            dash_pos = '0;
            drawing = 1'b1;
            return pix;
        end
        if (!drawing) begin
            return pix;
        end
        pix_on = dash_mask[dash_pos];
        pix_fits = int'(pen_x) >= 0 && int'(pen_x) < SCREEN_WIDTH &&
                   int'(pen_y) >= 0 && int'(pen_y) < SCREEN_HEIGHT;
        if (pix_on && pix_fits) begin
            pix.write_enable = 1'b1;
            pix.byte_offset = OFFSET_W'(int'(pen_y) * ROW_BYTES + int'(pen_x) / 4);
            pix.pixel_slot = pen_x[1:0];
            pix.pixel_value = pen_color[1:0];
        end
        if (pen_x == goal_x && pen_y == goal_y) begin
            pix.last = 1'b1;
            drawing = 1'b0;
            return pix;
        end
        e2 = 2 * int'(bres_err);
        if (e2 > -int'(run_y)) begin
            bres_err = ERROR_W'(int'(bres_err) - int'(run_y));
            pen_x = COORD_W'(int'(pen_x) + (x_back ? -1 : 1));
        end
        if (e2 < int'(run_x)) begin
            bres_err = ERROR_W'(int'(bres_err) + int'(run_x));
            pen_y = COORD_W'(int'(pen_y) + (y_back ? -1 : 1));
        end
        dash_pos = dash_pos + 4'd1;
        return pix;
    endfunction

    function automatic t_in_item make_step();
        t_in_item s;
        s.op = OP_STEP;
        s.start_x = COORD_W'($urandom);
        s.start_y = COORD_W'($urandom);
        s.end_x = COORD_W'($urandom);
        s.end_y = COORD_W'($urandom);
        return s;
    endfunction

    task automatic queue_line(input int x1, y1, x2, y2, steps);
        t_in_item s;
        s.op = OP_START;
        s.start_x = COORD_W'(x1);
        s.start_y = COORD_W'(y1);
        s.end_x = COORD_W'(x2);
        s.end_y = COORD_W'(y2);
        draw_cmds.push_back(s);
        repeat (steps) draw_cmds.push_back(make_step());
    endtask

    task automatic fill_random_lines(input int budget);
        int queued, pick, span, x1, y1, x2, y2, dxa, dya, full, steps;
        queued = 0;
        while (queued < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                draw_cmds.push_back(make_step());
                queued++;
            end else begin
                if (pick < 14) begin
                    x1 = int'($urandom_range(0, 4095)) - 2048;
                    y1 = int'($urandom_range(0, 4095)) - 2048;
                    x2 = int'($urandom_range(0, 4095)) - 2048;
                    y2 = int'($urandom_range(0, 4095)) - 2048;
                    steps = $urandom_range(0, 20);
                end else begin
                    span = (pick < 24) ? 160 : 12;
                    x1 = int'($urandom_range(0, 359)) - 20;
                    y1 = int'($urandom_range(0, 239)) - 20;
                    x2 = x1 + int'($urandom_range(0, 2 * span)) - span;
                    y2 = y1 + int'($urandom_range(0, 2 * span)) - span;
                    dxa = (x2 > x1) ? x2 - x1 : x1 - x2;
                    dya = (y2 > y1) ? y2 - y1 : y1 - y2;
                    full = ((dxa > dya) ? dxa : dya) + 1;
                    if ($urandom_range(0, 9) == 0) begin
                        steps = $urandom_range(0, full - 1);
                    end else begin
                        steps = full + (($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 2)) : 0);
                    end
                end
                queue_line(x1, y1, x2, y2, steps);
                queued += steps + 1;
            end
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_DASH_PATTERN) begin
            dash_mask = data[15:0];
        end else if (idx == CFG_DRAW_COLOR) begin
            pen_color = data[3:0];
        end
    endtask

    task automatic settle_engine();
        while (draw_cmds.size() != 0 || expected_pixels.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t mismatch on %s: expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_pixels.push_back(rasterize_beat(i_in_item));
                void'(draw_cmds.pop_front());
            end
            if (!i_in_valid || !o_in_stall) begin
                if (draw_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_item <= draw_cmds[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t unexpected result beat: expected none, actual %h", $time, o_out_item);
                mismatches++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("write_enable", want.write_enable, o_out_item.write_enable);
                check_field("byte_offset", want.byte_offset, o_out_item.byte_offset);
                check_field("pixel_slot", want.pixel_slot, o_out_item.pixel_slot);
                check_field("pixel_value", want.pixel_value, o_out_item.pixel_value);
                check_field("last", want.last, o_out_item.last);
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    initial begin
        dash_sets[4] = 16'($urandom);
        color_sets[4] = 16'($urandom);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int seg = 0; seg < 6; seg++) begin
            send_idle_pct = (seg < 2) ? 33 : (seg < 4) ? 47 : 0;
            recv_stall_pct = (seg < 2) ? 47 : (seg < 4) ? 33 : 0;
            if (seg == 0) begin
                @(negedge i_clk);
                draw_cmds.push_back(make_step());
                queue_line(0, 0, 3, 0, 4);
                draw_cmds.push_back(make_step());
                queue_line(5, 5, 5, 5, 1);
                queue_line(319, 199, 321, 201, 3);
                queue_line(-2048, -2048, 2047, 2047, 2);
                queue_line(2047, 2047, -2048, -2048, 1);
                queue_line(2, -1, 2, 1, 3);
                queue_line(10, 3, 8, 8, 6);
                fill_random_lines(200);
            end else begin
                settle_engine();
                cfg_write(CFG_DASH_PATTERN, dash_sets[seg]);
                cfg_write(CFG_DRAW_COLOR, color_sets[seg]);
                if (seg == 2) begin
                    cfg_write(CFG_SPARE_A, 16'($urandom));
                    cfg_write(CFG_SPARE_B, 16'($urandom));
                end
                @(negedge i_clk);
                fill_random_lines(235);
            end
        end
        settle_engine();
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
